// File: rtl/core/prf_pkg.sv
// Shared types, codes and reset values for the pulse frame receiver.
package prf_pkg;

    // Default sizes handed to the top level parameters
    localparam int FRAME_BITS_DEF = 32;
    localparam int TICK_BITS_DEF  = 16;

    // Result and register widths
    localparam int DATA_W   = 32;
    localparam int FLEN_W   = 6;
    localparam int SHIFT_W  = 5;
    localparam int THRESH_W = 16;
    localparam int SKIP_W   = 8;
    localparam int CMD_W    = 2;
    localparam int REG_IDX_W = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RISE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FALL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ID_SHIFT      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ID_MASK       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DATA_SHIFT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DATA_MASK     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BIT_THRESHOLD = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GAP_THRESHOLD = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SKIP_AFTER    = 3'd7;

    // Register reset values
    localparam logic [FLEN_W-1:0]   RST_FRAME_LENGTH  = 6'd25;
    localparam logic [SHIFT_W-1:0]  RST_ID_SHIFT      = 5'd5;
    localparam logic [DATA_W-1:0]   RST_ID_MASK       = 32'h000F_FFFF;
    localparam logic [SHIFT_W-1:0]  RST_DATA_SHIFT    = 5'd1;
    localparam logic [DATA_W-1:0]   RST_DATA_MASK     = 32'h0000_000F;
    localparam logic [THRESH_W-1:0] RST_BIT_THRESHOLD = 16'd100;
    localparam logic [THRESH_W-1:0] RST_GAP_THRESHOLD = 16'd300;
    localparam logic [SKIP_W-1:0]   RST_SKIP_AFTER    = 8'd3;

    typedef struct packed {
        logic [FLEN_W-1:0]   frame_length;
        logic [SHIFT_W-1:0]  id_shift;
        logic [DATA_W-1:0]   id_mask;
        logic [SHIFT_W-1:0]  data_shift;
        logic [DATA_W-1:0]   data_mask;
        logic [THRESH_W-1:0] bit_threshold;
        logic [THRESH_W-1:0] gap_threshold;
        logic [SKIP_W-1:0]   skip_after_read;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] expected_id;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] read_data;
        logic              id_matched;
    } result_t;

endpackage

// File: rtl/core/prf_cfg_regs.sv
// Configuration register file of the pulse frame receiver.
module prf_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [prf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [prf_pkg::DATA_W-1:0]        cfg_wdata,
    output prf_pkg::cfg_t                     cfg
);

    prf_pkg::cfg_t cfg_reg;
    prf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                prf_pkg::REG_FRAME_LENGTH:
                    cfg_next.frame_length = cfg_wdata[prf_pkg::FLEN_W-1:0];
                prf_pkg::REG_ID_SHIFT:
                    cfg_next.id_shift = cfg_wdata[prf_pkg::SHIFT_W-1:0];
                prf_pkg::REG_ID_MASK:
                    cfg_next.id_mask = cfg_wdata;
                prf_pkg::REG_DATA_SHIFT:
                    cfg_next.data_shift = cfg_wdata[prf_pkg::SHIFT_W-1:0];
                prf_pkg::REG_DATA_MASK:
                    cfg_next.data_mask = cfg_wdata;
                prf_pkg::REG_BIT_THRESHOLD:
                    cfg_next.bit_threshold = cfg_wdata[prf_pkg::THRESH_W-1:0];
                prf_pkg::REG_GAP_THRESHOLD:
                    cfg_next.gap_threshold = cfg_wdata[prf_pkg::THRESH_W-1:0];
                prf_pkg::REG_SKIP_AFTER:
                    cfg_next.skip_after_read = cfg_wdata[prf_pkg::SKIP_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length    <= prf_pkg::RST_FRAME_LENGTH;
            cfg_reg.id_shift        <= prf_pkg::RST_ID_SHIFT;
            cfg_reg.id_mask         <= prf_pkg::RST_ID_MASK;
            cfg_reg.data_shift      <= prf_pkg::RST_DATA_SHIFT;
            cfg_reg.data_mask       <= prf_pkg::RST_DATA_MASK;
            cfg_reg.bit_threshold   <= prf_pkg::RST_BIT_THRESHOLD;
            cfg_reg.gap_threshold   <= prf_pkg::RST_GAP_THRESHOLD;
            cfg_reg.skip_after_read <= prf_pkg::RST_SKIP_AFTER;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/prf_in_stage.sv
// Input register stage: captures one transfer and holds it until executed.
module prf_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  prf_pkg::item_t        s_item,
    output logic                  item_valid,
    output prf_pkg::item_t        item,
    input  logic                  item_take
);

    logic           valid_reg;
    logic           valid_next;
    prf_pkg::item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/prf_decode.sv
// Decoder state and per-item update: tick counter, bit capture, frame cut, read.
module prf_decode #(
    parameter int FRAME_BITS = prf_pkg::FRAME_BITS_DEF,
    parameter int TICK_BITS  = prf_pkg::TICK_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              exec,
    input  prf_pkg::item_t    item,
    input  prf_pkg::cfg_t     cfg,
    output prf_pkg::result_t  result
);

    localparam int CMP_W = (TICK_BITS > prf_pkg::THRESH_W) ? TICK_BITS : prf_pkg::THRESH_W;
    localparam int EXT_W = (FRAME_BITS > prf_pkg::DATA_W) ? FRAME_BITS : prf_pkg::DATA_W;
    localparam int IDX_W = $clog2(FRAME_BITS);
    localparam int POS_W = prf_pkg::FLEN_W + 2;
    localparam logic [POS_W-1:0] FRAME_LIM = POS_W'(FRAME_BITS);
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    logic [TICK_BITS-1:0]        tick_count_reg, tick_count_next;
    logic [prf_pkg::FLEN_W-1:0]  bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0]       frame_shift_reg, frame_shift_next;
    logic [prf_pkg::DATA_W-1:0]  held_id_reg, held_id_next;
    logic [prf_pkg::DATA_W-1:0]  held_data_reg, held_data_next;
    logic [prf_pkg::SKIP_W-1:0]  skip_count_reg, skip_count_next;

    logic                        high_long;
    logic                        gap_long;
    logic signed [POS_W-1:0]     pos;
    logic                        pos_ok;
    logic [IDX_W-1:0]            pos_idx;
    logic [FRAME_BITS-1:0]       frame_fill;
    logic [prf_pkg::FLEN_W:0]    index_inc;
    logic                        frame_done;
    logic [prf_pkg::SKIP_W-1:0]  skip_dec;
    logic [EXT_W-1:0]            frame_ext;
    logic [EXT_W-1:0]            id_shifted;
    logic [EXT_W-1:0]            data_shifted;
    logic                        id_match;

    assign high_long = CMP_W'(tick_count_reg) > CMP_W'(cfg.bit_threshold);
    assign gap_long  = CMP_W'(tick_count_reg) > CMP_W'(cfg.gap_threshold);

    // Bit position, MSB first; negative or past the frame register means no write
    assign pos     = $signed({2'b00, cfg.frame_length}) - POS_W'(1)
                     - $signed({2'b00, bit_index_reg});
    assign pos_ok  = !pos[POS_W-1] && ($unsigned(pos) < FRAME_LIM);
    assign pos_idx = pos[IDX_W-1:0];

    always_comb begin
        frame_fill = frame_shift_reg;
        for (int i = 0; i < FRAME_BITS; i++) begin
            if (pos_ok && (pos_idx == IDX_W'(i))) begin
                frame_fill[i] = high_long;
            end
        end
    end

    assign index_inc  = {1'b0, bit_index_reg} + 1'b1;
    assign frame_done = index_inc >= {1'b0, cfg.frame_length};
    assign skip_dec   = (skip_count_reg != '0) ? (skip_count_reg - 1'b1) : skip_count_reg;

    // Fields are cut from the frame including the bit just stored
    assign frame_ext    = EXT_W'(frame_fill);
    assign id_shifted   = frame_ext >> cfg.id_shift;
    assign data_shifted = frame_ext >> cfg.data_shift;

    assign id_match = held_id_reg == item.expected_id;

    always_comb begin
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        frame_shift_next = frame_shift_reg;
        held_id_next     = held_id_reg;
        held_data_next   = held_data_reg;
        skip_count_next  = skip_count_reg;
        result.valid      = 1'b0;
        result.read_data  = '0;
        result.id_matched = 1'b0;
        if (exec) begin
            case (item.command)
                prf_pkg::CMD_TICK: begin
                    if (tick_count_reg != TICK_MAX) begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
                prf_pkg::CMD_RISE: begin
                    if (gap_long) begin
                        bit_index_next = '0;
                    end
                    tick_count_next = '0;
                end
                prf_pkg::CMD_FALL: begin
                    frame_shift_next = frame_fill;
                    if (frame_done) begin
                        bit_index_next  = '0;
                        skip_count_next = skip_dec;
                        if (skip_dec == '0) begin
                            held_id_next   = id_shifted[prf_pkg::DATA_W-1:0] & cfg.id_mask;
                            held_data_next = data_shifted[prf_pkg::DATA_W-1:0]
                                             & cfg.data_mask;
                        end
                    end else begin
                        bit_index_next = index_inc[prf_pkg::FLEN_W-1:0];
                    end
                end
                prf_pkg::CMD_READ: begin
                    result.valid = 1'b1;
                    if (id_match) begin
                        result.read_data  = held_data_reg;
                        result.id_matched = 1'b1;
                        held_id_next      = '0;
                        held_data_next    = '0;
                        skip_count_next   = cfg.skip_after_read;
                    end else begin
                        skip_count_next = '0;
                    end
                end
                default: begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            frame_shift_reg <= '0;
            held_id_reg     <= '0;
            held_data_reg   <= '0;
            skip_count_reg  <= '0;
        end else begin
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            frame_shift_reg <= frame_shift_next;
            held_id_reg     <= held_id_next;
            held_data_reg   <= held_data_next;
            skip_count_reg  <= skip_count_next;
        end
    end

endmodule

// File: rtl/core/pwm_pulse_frame_receiver.sv
// Top level of the pulse-width remote frame receiver.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | s_command, s_expected_id
//  m_       | out       | m_valid / m_ready  | m_read_data, m_id_matched
//  cfg_     | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One transfer per cycle is sustained unless a read waits on a full result register; an
// input transfer lands in the input register and executes from it, and a read result
// is registered in the result register before it shows on m_. A single decode stage
// lies between the input register and the result register.
// Reset is synchronous, active low, and clears all decoder state to zero and the
// registers to their defaults. While a result waits on m_ready, ticks and edges
// still execute; only a following read holds in the input register.
module pwm_pulse_frame_receiver #(
    parameter int FRAME_BITS = prf_pkg::FRAME_BITS_DEF,
    parameter int TICK_BITS  = prf_pkg::TICK_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prf_pkg::CMD_W-1:0]         s_command,
    input  logic [prf_pkg::DATA_W-1:0]        s_expected_id,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prf_pkg::DATA_W-1:0]        m_read_data,
    output logic                              m_id_matched,
    input  logic                              cfg_we,
    input  logic [prf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [prf_pkg::DATA_W-1:0]        cfg_wdata
);

    prf_pkg::cfg_t    cfg;
    prf_pkg::item_t   s_item;
    prf_pkg::item_t   item;
    prf_pkg::result_t result;
    logic             item_valid;
    logic             out_free;
    logic             exec;

    logic                        m_valid_reg, m_valid_next;
    logic [prf_pkg::DATA_W-1:0]  m_read_data_reg;
    logic                        m_id_matched_reg;

    prf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_item.command     = s_command;
    assign s_item.expected_id = s_expected_id;

    prf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (exec)
    );

    // Result register frees when empty or when its transfer completes
    assign out_free = !m_valid_reg || m_ready;

    // Only a read needs the result register; everything else executes at once
    assign exec = item_valid && ((item.command != prf_pkg::CMD_READ) || out_free);

    prf_decode #(
        .FRAME_BITS (FRAME_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (exec),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the payload only with a new result; hold it while stalled
    always_ff @(posedge aclk) begin
        if (out_free && result.valid) begin
            m_read_data_reg  <= result.read_data;
            m_id_matched_reg <= result.id_matched;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_id_matched = m_id_matched_reg;

endmodule

// File: rtl/core/prf_checker.sv
// Port-level checker for the pulse frame receiver, bound to the top level.
module prf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [prf_pkg::CMD_W-1:0]         s_command,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [prf_pkg::DATA_W-1:0]        m_read_data,
    input logic                              m_id_matched
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_id_matched))
        else $error("result changed while stalled");

    // A mismatch returns zero data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_id_matched |-> m_read_data == '0)
        else $error("mismatched read returned nonzero data");

    // With the result side empty, input transfers are never refused
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A new result follows an earlier accepted read transfer
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |->
            $past(s_valid && s_ready && (s_command == prf_pkg::CMD_READ), 2))
        else $error("result without a read transfer");

endmodule

bind pwm_pulse_frame_receiver prf_checker u_prf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_id_matched (m_id_matched)
);

// File: test/tb_top.sv
// Self-checking testbench for the pulse-width remote frame receiver.
`timescale 1ns / 1ps

module tb_top;

    // Run shape
    localparam int RANDOM_ITEMS   = 1750;
    localparam int MIN_READS      = 80;
    localparam int SETTLE_CYCLES  = 4;     // input register plus decode stage, with margin
    localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int LONG_TICKS     = 101;   // one past the threshold of the long-high check

    localparam int TICK_W = prf_pkg::TICK_BITS_DEF;

    typedef struct packed {
        logic [prf_pkg::DATA_W-1:0] data;
        logic                       matched;
    } read_result_t;

    typedef enum logic {ROW_ITEM, ROW_SETTINGS} row_kind_t;

    // One line of the directed stimulus; typed rows carry their own answer
    typedef struct {
        row_kind_t                  kind;
        logic [prf_pkg::CMD_W-1:0]  cmd;
        logic [prf_pkg::DATA_W-1:0] id;
        bit                         typed;
        read_result_t               want;
        prf_pkg::cfg_t              settings;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [prf_pkg::CMD_W-1:0]     s_command;
    logic [prf_pkg::DATA_W-1:0]    s_expected_id;
    logic                          m_valid;
    logic                          m_ready;
    logic [prf_pkg::DATA_W-1:0]    m_read_data;
    logic                          m_id_matched;
    logic                          cfg_we;
    logic [prf_pkg::REG_IDX_W-1:0] cfg_index;
    logic [prf_pkg::DATA_W-1:0]    cfg_wdata;

    // Decoder state as the block should hold it
    prf_pkg::cfg_t                 rx_cfg;
    logic [TICK_W-1:0]             rx_tick;
    logic [prf_pkg::FLEN_W-1:0]    rx_bit_idx;
    logic [prf_pkg::DATA_W-1:0]    rx_frame;
    logic [prf_pkg::DATA_W-1:0]    rx_held_id;
    logic [prf_pkg::DATA_W-1:0]    rx_held_data;
    logic [prf_pkg::SKIP_W-1:0]    rx_skip;

    read_result_t         awaited_reads[$];
    stim_row_t            stim_rows[$];
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    int                   reads_total = 0;
    int                   burst_left = 0;
    bit                   hold_off_req = 1'b0;

    pwm_pulse_frame_receiver DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_expected_id (s_expected_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_id_matched  (m_id_matched),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // Advance the predicted decoder by one accepted transfer.
    task automatic decode_transfer(input logic [prf_pkg::CMD_W-1:0] cmd,
                                   input logic [prf_pkg::DATA_W-1:0] id,
                                   output bit has_result, output read_result_t res);
        int pos;
        has_result = 1'b0;
        res = '0;
        case (cmd)
            prf_pkg::CMD_TICK: begin
                if (rx_tick != '1)
                    rx_tick = rx_tick + 1'b1;
            end
            prf_pkg::CMD_RISE: begin
                // a long quiet spell before the edge restarts the frame
                if (rx_tick > rx_cfg.gap_threshold)
                    rx_bit_idx = '0;
                rx_tick = '0;
            end
            prf_pkg::CMD_FALL: begin
                // MSB first; positions off either end of the frame register drop the bit
                pos = int'(rx_cfg.frame_length) - 1 - int'(rx_bit_idx);
                if (pos >= 0 && pos < prf_pkg::DATA_W)
                    rx_frame[pos] = (rx_tick > rx_cfg.bit_threshold);
                if (int'(rx_bit_idx) + 1 >= int'(rx_cfg.frame_length)) begin
                    rx_bit_idx = '0;
                    if (rx_skip != '0)
                        rx_skip = rx_skip - 1'b1;
                    if (rx_skip == '0) begin
                        rx_held_id   = (rx_frame >> rx_cfg.id_shift) & rx_cfg.id_mask;
                        rx_held_data = (rx_frame >> rx_cfg.data_shift) & rx_cfg.data_mask;
                    end
                end else begin
                    rx_bit_idx = rx_bit_idx + 1'b1;
                end
            end
            default: begin
                has_result = 1'b1;
                reads_total++;
                if (rx_held_id == id) begin
                    res.data     = rx_held_data;
                    res.matched  = 1'b1;
                    rx_held_id   = '0;
                    rx_held_data = '0;
                    rx_skip      = rx_cfg.skip_after_read;
                end else begin
                    rx_skip = '0;
                end
            end
        endcase
    endtask

    // Drop valid and keep it low for the idle time that n gives.
    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Offer one transfer, wait for it to be taken, then predict it.
    task automatic send_item(input logic [prf_pkg::CMD_W-1:0] cmd,
                             input logic [prf_pkg::DATA_W-1:0] id,
                             input bit typed = 1'b0, input read_result_t want = '0);
        bit           has_result;
        read_result_t res;
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_expected_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_transfer(cmd, id, has_result, res);
        if (has_result)
            awaited_reads.push_back(typed ? want : res);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // mostly short bursts, now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
            idle_sender($urandom_range(1, 6));
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(prf_pkg::CMD_TICK, $urandom);
    endtask

    // Hold the sender until every read result is in and the pipeline is empty.
    task automatic drain_results();
        idle_sender(1);
        while (awaited_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [prf_pkg::REG_IDX_W-1:0] idx,
                             input logic [prf_pkg::DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Write every register, then mirror the settings into the predictor.
    task automatic apply_settings(input prf_pkg::cfg_t c);
        write_reg(prf_pkg::REG_FRAME_LENGTH,  prf_pkg::DATA_W'(c.frame_length));
        write_reg(prf_pkg::REG_ID_SHIFT,      prf_pkg::DATA_W'(c.id_shift));
        write_reg(prf_pkg::REG_ID_MASK,       c.id_mask);
        write_reg(prf_pkg::REG_DATA_SHIFT,    prf_pkg::DATA_W'(c.data_shift));
        write_reg(prf_pkg::REG_DATA_MASK,     c.data_mask);
        write_reg(prf_pkg::REG_BIT_THRESHOLD, prf_pkg::DATA_W'(c.bit_threshold));
        write_reg(prf_pkg::REG_GAP_THRESHOLD, prf_pkg::DATA_W'(c.gap_threshold));
        write_reg(prf_pkg::REG_SKIP_AFTER,    prf_pkg::DATA_W'(c.skip_after_read));
        cfg_we <= 1'b0;
        rx_cfg = c;
    endtask

    // Mostly ask for the id the decoder holds, so matches and data returns happen often.
    function automatic logic [prf_pkg::DATA_W-1:0] pick_read_id();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return rx_held_id;
        if (sel < 15)
            return rx_held_id ^ (32'd1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    // One pulse train: lead ticks (a long gap only under a gap threshold below 16), then a rise/high/fall/low per bit.
    // A broken train stops part way and, under such a threshold, uses a short gap.
    task automatic send_frame(input bit broken);
        int n_bits, stop_at, lead, bit_thr, gap_thr;
        bit_thr = int'(rx_cfg.bit_threshold);
        gap_thr = int'(rx_cfg.gap_threshold);
        n_bits  = (rx_cfg.frame_length == '0) ? 1 : int'(rx_cfg.frame_length);
        stop_at = broken ? $urandom_range(0, n_bits - 1) : n_bits;
        if (gap_thr < 16)
            lead = broken ? $urandom_range(0, gap_thr) : gap_thr + 1 + $urandom_range(0, 2);
        else
            lead = $urandom_range(0, 4);
        send_ticks(lead);
        for (int b = 0; b < stop_at; b++) begin
            send_item(prf_pkg::CMD_RISE, $urandom);
            send_ticks((bit_thr < 8) ? $urandom_range(0, bit_thr + 1) : $urandom_range(0, 3));
            send_item(prf_pkg::CMD_FALL, $urandom);
            send_ticks($urandom_range(0, 1));
        end
    endtask

    task automatic add_row(input logic [prf_pkg::CMD_W-1:0] cmd,
                           input logic [prf_pkg::DATA_W-1:0] id,
                           input bit typed = 1'b0, input logic [prf_pkg::DATA_W-1:0] data = '0,
                           input logic matched = 1'b0);
        stim_row_t r;
        r = '{kind: ROW_ITEM, cmd: cmd, id: id, typed: typed,
              want: '{data: data, matched: matched}, settings: '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_settings(input prf_pkg::cfg_t c);
        stim_row_t r;
        r = '{kind: ROW_SETTINGS, cmd: prf_pkg::CMD_TICK, id: '0, typed: 1'b0, want: '0,
              settings: c};
        stim_rows.push_back(r);
    endtask

    // Receiver: stall on a pattern picked anew for each random-length segment; on request,
    // hold off for one long stretch so the block backs up into its input.
    initial begin : result_sink
        int seg_left, mode;
        m_ready  = 1'b0;
        seg_left = 0;
        mode     = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Compare each result transfer against the oldest pending read.
    always @(posedge aclk) begin : result_check
        read_result_t head;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_reads.size() == 0) begin
                report_mismatch("result with no read pending", 32'd0, m_read_data);
            end else begin
                head = awaited_reads.pop_front();
                if (m_read_data !== head.data)
                    report_mismatch("read_data", head.data, m_read_data);
                if (m_id_matched !== head.matched)
                    report_mismatch("id_matched", 32'(head.matched), 32'(m_id_matched));
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("pwm_pulse_frame_receiver verification failed");
        $finish;
    end

    initial begin : stimulus
        prf_pkg::cfg_t next_cfg;
        int            rand_start, frame_no, pick, bit_thr;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = prf_pkg::CMD_TICK;
        s_expected_id = '0;
        cfg_we        = 1'b0;
        cfg_index     = prf_pkg::REG_FRAME_LENGTH;
        cfg_wdata     = '0;

        rx_cfg = '{frame_length: prf_pkg::RST_FRAME_LENGTH, id_shift: prf_pkg::RST_ID_SHIFT,
                   id_mask: prf_pkg::RST_ID_MASK, data_shift: prf_pkg::RST_DATA_SHIFT,
                   data_mask: prf_pkg::RST_DATA_MASK,
                   bit_threshold: prf_pkg::RST_BIT_THRESHOLD,
                   gap_threshold: prf_pkg::RST_GAP_THRESHOLD,
                   skip_after_read: prf_pkg::RST_SKIP_AFTER};
        rx_tick      = '0;
        rx_bit_idx   = '0;
        rx_frame     = '0;
        rx_held_id   = '0;
        rx_held_data = '0;
        rx_skip      = '0;

        // Directed part, reset settings: held id and data are zero after reset, so id 0
        // matches with empty data and any other id misses.
        add_row(prf_pkg::CMD_READ, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        add_row(prf_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
        add_row(prf_pkg::CMD_READ, 32'h0000_0000, 1'b1, 32'h0, 1'b1);
        add_row(prf_pkg::CMD_TICK, 32'hFFFF_FFFF);
        add_row(prf_pkg::CMD_FALL, 32'h0000_0000);
        add_row(prf_pkg::CMD_READ, 32'h0000_0001, 1'b1, 32'h0, 1'b0);

        // Two-bit frames, zero bit threshold, skip count of one after a match (the next frame is still taken)
        add_settings('{frame_length: 6'd2, id_shift: 5'd1, id_mask: 32'hFFFF_FFFF,
                       data_shift: 5'd0, data_mask: 32'hFFFF_FFFF, bit_threshold: 16'd0,
                       gap_threshold: 16'd3, skip_after_read: 8'd1});
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_RISE, 32'h0);
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_FALL, 32'h0);
        add_row(prf_pkg::CMD_RISE, 32'h0);
        add_row(prf_pkg::CMD_FALL, 32'h0);
        add_row(prf_pkg::CMD_READ, 32'h0000_0001);
        add_row(prf_pkg::CMD_RISE, 32'h0);
        add_row(prf_pkg::CMD_TICK, 32'h0);
        add_row(prf_pkg::CMD_FALL, 32'h0);
        add_row(prf_pkg::CMD_FALL, 32'h0);
        add_row(prf_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
        add_row(prf_pkg::CMD_READ, 32'h0000_0001);

        // Zero frame length: every falling edge closes a frame and writes no bit
        add_settings('{frame_length: 6'd0, id_shift: 5'd31, id_mask: 32'hFFFF_FFFF,
                       data_shift: 5'd31, data_mask: 32'h0, bit_threshold: 16'hFFFF,
                       gap_threshold: 16'hFFFF, skip_after_read: 8'hFF});
        add_row(prf_pkg::CMD_FALL, 32'h0);
        add_row(prf_pkg::CMD_READ, 32'h0000_0000);
        add_row(prf_pkg::CMD_FALL, 32'h0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_SETTINGS) begin
                drain_results();
                apply_settings(stim_rows[i].settings);
            end else begin
                send_item(stim_rows[i].cmd, stim_rows[i].id, stim_rows[i].typed,
                          stim_rows[i].want);
            end
        end

        // Long high time against a wide threshold: one-bit frames, so the bit lands in bit 0
        // of the held id. Clear the skip counter first with a missed read.
        drain_results();
        apply_settings('{frame_length: 6'd1, id_shift: 5'd0, id_mask: 32'hFFFF_FFFF,
                         data_shift: 5'd0, data_mask: 32'hFFFF_FFFF, bit_threshold: 16'd100,
                         gap_threshold: 16'd100, skip_after_read: 8'd0});
        send_item(prf_pkg::CMD_READ, ~rx_held_id);
        send_item(prf_pkg::CMD_RISE, 32'h0);
        burst_left = LONG_TICKS + 8;
        send_ticks(LONG_TICKS);
        send_item(prf_pkg::CMD_FALL, 32'h0);
        send_item(prf_pkg::CMD_READ, rx_held_id);
        send_item(prf_pkg::CMD_RISE, 32'h0);
        burst_left = 0;

        // Random part: mostly well-formed pulse trains, with broken trains and noise,
        // under a new register setting every few frames.
        rand_start = items_sent;
        frame_no   = 0;
        while (items_sent - rand_start < RANDOM_ITEMS || reads_total < MIN_READS) begin
            if (frame_no % 6 == 0) begin
                case ($urandom_range(0, 9))
                    0:       next_cfg.frame_length = 6'd0;
                    1:       next_cfg.frame_length = 6'($urandom_range(24, 32));
                    2:       next_cfg.frame_length = 6'($urandom_range(33, 63));
                    default: next_cfg.frame_length = 6'($urandom_range(1, 8));
                endcase
                next_cfg.id_shift   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                  : 5'($urandom_range(0, 3));
                next_cfg.data_shift = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                                  : 5'($urandom_range(0, 3));
                case ($urandom_range(0, 5))
                    0:       next_cfg.id_mask = 32'h0;
                    1:       next_cfg.id_mask = 32'hFFFF_FFFF;
                    default: next_cfg.id_mask = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       next_cfg.data_mask = 32'h0;
                    1:       next_cfg.data_mask = 32'hFFFF_FFFF;
                    default: next_cfg.data_mask = $urandom;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    next_cfg.bit_threshold = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0;
                    next_cfg.gap_threshold = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0;
                end else begin
                    bit_thr = $urandom_range(0, 3);
                    next_cfg.bit_threshold = 16'(bit_thr);
                    next_cfg.gap_threshold = 16'(bit_thr + $urandom_range(3, 6));
                end
                next_cfg.skip_after_read = ($urandom_range(0, 7) == 0) ? 8'hFF
                                                                       : 8'($urandom_range(0, 2));
                drain_results();
                apply_settings(next_cfg);
            end

            // Back up the block: receiver holds off while reads keep coming
            if (frame_no == 8) begin
                hold_off_req = 1'b1;
                for (int k = 0; k < 40; k++)
                    send_item((k % 4 == 0) ? prf_pkg::CMD_READ : prf_pkg::CMD_TICK,
                              pick_read_id());
            end

            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(1'b0);
            end else if (pick == 7) begin
                send_frame(1'b1);
            end else begin
                repeat ($urandom_range(4, 12))
                    send_item(prf_pkg::CMD_W'($urandom_range(0, 3)), $urandom);
            end
            repeat ($urandom_range(0, 2))
                send_item(prf_pkg::CMD_READ, pick_read_id());
            frame_no++;
        end

        drain_results();
        if (mismatch_count == 0)
            $display("pwm_pulse_frame_receiver verification clean");
        else
            $display("pwm_pulse_frame_receiver verification failed");
        $finish;
    end

endmodule
